[src/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, status codes and lead byte decode for the UTF-8 stream
// decoder (six-byte form).
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_BAD_CONT    = 2'd2;
  localparam logic [1:0] ST_ZERO_TRUNC  = 2'd3;

  // Payload masks of the lead byte, by sequence width
  localparam logic [6:0] MASK_W1 = 7'b1111111;
  localparam logic [6:0] MASK_W2 = 7'b0011111;
  localparam logic [6:0] MASK_W3 = 7'b0001111;
  localparam logic [6:0] MASK_W4 = 7'b0000111;
  localparam logic [6:0] MASK_W5 = 7'b0000011;
  localparam logic [6:0] MASK_W6 = 7'b0000001;

  // Continuation byte marker in the top two bits
  localparam logic [1:0] CONT_TAG = 2'b10;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // One result item
  typedef struct packed {
    logic [30:0] code_point;
    logic [2:0]  seq_width;
    logic [1:0]  status;
    logic        is_last;
  } u8d_res_t;

  // All results caused by one input byte (one or two)
  typedef struct packed {
    logic     two;
    u8d_res_t first;
    u8d_res_t second;
  } u8d_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } u8d_qstat_t;

  // Lead byte decode: width 0 means invalid lead
  typedef struct packed {
    logic [2:0] width;
    logic [6:0] mask;
  } u8d_lead_t;

  function automatic u8d_lead_t lead_decode(input logic [7:0] b);
    u8d_lead_t l;
    casez (b)
      8'b0???????: begin l.width = 3'd1; l.mask = MASK_W1; end
      8'b10??????: begin l.width = 3'd0; l.mask = '0;      end
      8'b110?????: begin l.width = 3'd2; l.mask = MASK_W2; end
      8'b1110????: begin l.width = 3'd3; l.mask = MASK_W3; end
      8'b11110???: begin l.width = 3'd4; l.mask = MASK_W4; end
      8'b111110??: begin l.width = 3'd5; l.mask = MASK_W5; end
      8'b1111110?: begin l.width = 3'd6; l.mask = MASK_W6; end
      default:     begin l.width = 3'd0; l.mask = '0;      end
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

[src/utf8_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Byte-serial decoder for the original six-byte UTF-8 form.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle while the queue is not full, and gives
// one result per cycle while the output is ready. A byte that breaks a
// sequence and is itself a one-byte character or an invalid lead gives two
// results (the error, then the byte's own result), handed out one after the
// other; the queue of QUEUE_DEPTH entries between the input decode and the
// output register absorbs such bursts and output stalls. An input byte is
// decoded in the cycle it is taken; its first result passes through the
// queue and then the output register. Sustained rate is one result per
// cycle, set by the output register delivering one result per transfer.
`default_nettype none

module utf8_stream_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [30:0] code_point, [33:31] seq_width,
                                  // [35:34] status, [39:36] zero
  output logic        out_tlast   // is_last
);
  import u8d_pkg::*;

  u8d_qstat_t qstat;
  u8d_entry_t push_entry;
  u8d_entry_t pop_entry;
  u8d_res_t   out_res;
  logic       push;
  logic       pop;

  u8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  u8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  u8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Output packing
  assign out_tdata = {4'd0, out_res.status, out_res.seq_width, out_res.code_point};
  assign out_tlast = out_res.is_last;

endmodule

`default_nettype wire

[src/u8d_front.sv]
// ----------------------------------------------------------------------------
// u8d_front
// Accepts one byte per cycle while the queue is not full, tracks the open
// sequence and builds the results that the byte causes as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [7:0]              in_byte,
  input  u8d_pkg::u8d_qstat_t     qstat,
  output logic                    push,
  output u8d_pkg::u8d_entry_t     push_entry
);
  import u8d_pkg::*;

  logic [2:0]  rem_r, rem_nxt;
  logic [2:0]  cw_r, cw_nxt;
  logic [30:0] acc_r, acc_nxt;

  u8d_lead_t   lead;
  u8d_res_t    lead_res;
  logic        lead_emits;
  logic        accept;
  logic        brk;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign brk      = (in_byte == 8'd0) || (in_byte[7:6] != CONT_TAG);

  // Result of decoding the byte as a lead (used when idle and after a break)
  always_comb begin
    lead = lead_decode(in_byte);
    lead_emits = (lead.width == 3'd0) || (lead.width == 3'd1);
    lead_res.is_last = 1'b1;
    if (lead.width == 3'd0) begin
      lead_res.code_point = '0;
      lead_res.seq_width  = 3'd0;
      lead_res.status     = ST_INVALID;
    end else begin
      lead_res.code_point = {24'd0, in_byte[6:0] & lead.mask};
      lead_res.seq_width  = 3'd1;
      lead_res.status     = ST_OK;
    end
  end

  // Sequence tracking and entry build
  always_comb begin
    rem_nxt    = rem_r;
    cw_nxt     = cw_r;
    acc_nxt    = acc_r;
    push       = 1'b0;
    push_entry = '0;
    if (accept) begin
      if (rem_r == 3'd0) begin
        if (lead_emits) begin
          push             = 1'b1;
          push_entry.first = lead_res;
        end else begin
          acc_nxt = {24'd0, in_byte[6:0] & lead.mask};
          cw_nxt  = lead.width;
          rem_nxt = lead.width - 3'd1;
        end
      end else if (brk) begin
        push                        = 1'b1;
        rem_nxt                     = 3'd0;
        push_entry.first.code_point = '0;
        push_entry.first.seq_width  = cw_r;
        push_entry.first.status     = (in_byte == 8'd0) ? ST_ZERO_TRUNC : ST_BAD_CONT;
        if (lead_emits) begin
          push_entry.two              = 1'b1;
          push_entry.first.is_last    = 1'b0;
          push_entry.second           = lead_res;
        end else begin
          // byte reopens a new sequence
          push_entry.first.is_last = 1'b1;
          acc_nxt = {24'd0, in_byte[6:0] & lead.mask};
          cw_nxt  = lead.width;
          rem_nxt = lead.width - 3'd1;
        end
      end else begin
        acc_nxt = {acc_r[24:0], in_byte[5:0]};
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          push                        = 1'b1;
          push_entry.first.code_point = {acc_r[24:0], in_byte[5:0]};
          push_entry.first.seq_width  = cw_r;
          push_entry.first.status     = ST_OK;
          push_entry.first.is_last    = 1'b1;
        end
      end
    end
  end

  // State registers; accumulator and width are loaded at each lead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      cw_r  <= 3'd0;
    end else begin
      rem_r <= rem_nxt;
      cw_r  <= cw_nxt;
    end
    acc_r <= acc_nxt;
  end

  // An open sequence always has room for its remaining bytes
  a_rem_in_width: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 3'd0) |-> (cw_r >= 3'd2 && rem_r < cw_r))
    else $error("remaining count exceeds sequence width");

  // In a pair, only the second result closes the byte
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.two) |-> (push_entry.second.is_last && !push_entry.first.is_last))
    else $error("is_last misplaced in result pair");

endmodule

`default_nettype wire

[src/u8d_fifo.sv]
// ----------------------------------------------------------------------------
// u8d_fifo
// Short queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_fifo #(
  parameter int unsigned DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  u8d_pkg::u8d_entry_t     push_entry,
  input  wire                     pop,
  output u8d_pkg::u8d_entry_t     pop_entry,
  output u8d_pkg::u8d_qstat_t     qstat
);
  import u8d_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u8d_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == FULL_CNT);
  assign qstat.empty = (cnt_r == '0);
  assign pop_entry   = slots[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

[src/u8d_back.sv]
// ----------------------------------------------------------------------------
// u8d_back
// Takes queue entries and hands their results out one per transfer through
// an output register, holding the second result of a pair aside.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  u8d_pkg::u8d_qstat_t     qstat,
  input  u8d_pkg::u8d_entry_t     pop_entry,
  output logic                    pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output u8d_pkg::u8d_res_t       out_res
);
  import u8d_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  u8d_res_t out_res_r, out_res_nxt;
  logic     sec_valid_r, sec_valid_nxt;
  u8d_res_t sec_r, sec_nxt;
  logic     out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Serialize: held second result first, then the next entry
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    sec_valid_nxt = sec_valid_r;
    sec_nxt       = sec_r;
    pop           = 1'b0;
    if (out_free) begin
      if (sec_valid_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = sec_r;
        sec_valid_nxt = 1'b0;
      end else if (!qstat.empty) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        out_res_nxt   = pop_entry.first;
        sec_valid_nxt = pop_entry.two;
        sec_nxt       = pop_entry.second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
    out_res_r <= out_res_nxt;
    sec_r     <= sec_nxt;
  end

  // A held second result always sits behind a shown first one
  a_sec_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> (out_valid_r && !out_res_r.is_last))
    else $error("second result held without its first");

  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_OK) |-> (out_res_r.code_point == '0))
    else $error("error result carries a code point");

endmodule

`default_nettype wire
